/* design/mhft_pkg.sv */
// Shared types, codes and constants for the multi-hash flow table.
// Used by every design module but mhft_ram, and by the testbench; depends on nothing.
`default_nettype none

package mhft_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;

    localparam int ID_W   = 31;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 3;
    localparam int HASH_W = 32;
    localparam int KEY_W  = 64;

    // Hash sequencer: mix hash is steps 0..MIX_LAST, Wang hash the rest
    localparam int HASH_STEPS = 12;
    localparam int MIX_LAST   = 5;
    localparam int STEP_W     = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [STAT_W-1:0] ST_SLOT0   = 3'd0;
    localparam logic [STAT_W-1:0] ST_COLLIDE = 3'd3;
    localparam logic [STAT_W-1:0] ST_READ    = 3'd4;

    typedef struct packed {
        logic             command;
        logic [ID_W-1:0]  flow_id;
        logic [IDX_W-1:0] slot_index;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slot;
        logic [ID_W-1:0]   stored_id;
        logic [HASH_W-1:0] first_hash;
        logic [HASH_W-1:0] second_hash;
        logic [HASH_W-1:0] third_hash;
    } t_out;

    typedef enum logic [2:0] {
        OP_NOTK_ADD_SHL,  // ~k + (k << n)
        OP_ADD_NOT_SHL,   // k + ~(k << n)
        OP_ADD_SHL,       // k + (k << n)
        OP_XOR_SAR,       // k ^ (k >>> n)
        OP_MUL21          // k * 21 as shift-adds
    } t_hash_op;

    typedef struct packed {
        t_hash_op   op;
        logic [4:0] shamt;
        logic       narrow;  // 32-bit arithmetic (sign taken from bit 31)
    } t_hash_step;

    function automatic t_hash_step hash_step(input logic [STEP_W-1:0] idx);
        t_hash_step s;
        s = '{op: OP_XOR_SAR, shamt: 5'd0, narrow: 1'b0};
        unique case (idx)
            4'd0:  s = '{op: OP_NOTK_ADD_SHL, shamt: 5'd18, narrow: 1'b0};
            4'd1:  s = '{op: OP_XOR_SAR,      shamt: 5'd31, narrow: 1'b0};
            4'd2:  s = '{op: OP_MUL21,        shamt: 5'd0,  narrow: 1'b0};
            4'd3:  s = '{op: OP_XOR_SAR,      shamt: 5'd11, narrow: 1'b0};
            4'd4:  s = '{op: OP_ADD_SHL,      shamt: 5'd6,  narrow: 1'b0};
            4'd5:  s = '{op: OP_XOR_SAR,      shamt: 5'd22, narrow: 1'b0};
            4'd6:  s = '{op: OP_ADD_NOT_SHL,  shamt: 5'd15, narrow: 1'b1};
            4'd7:  s = '{op: OP_XOR_SAR,      shamt: 5'd10, narrow: 1'b1};
            4'd8:  s = '{op: OP_ADD_SHL,      shamt: 5'd3,  narrow: 1'b1};
            4'd9:  s = '{op: OP_XOR_SAR,      shamt: 5'd6,  narrow: 1'b1};
            4'd10: s = '{op: OP_ADD_NOT_SHL,  shamt: 5'd11, narrow: 1'b1};
            4'd11: s = '{op: OP_XOR_SAR,      shamt: 5'd16, narrow: 1'b1};
            default: s = '{op: OP_XOR_SAR, shamt: 5'd0, narrow: 1'b0};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/multi_hash_flow_table.sv */
// Multi-hash flow table top: hash sequencer, probe control, slot RAM.
// Depends on mhft_pkg, mhft_hash_alu, mhft_mod and mhft_ram.
// Insert: hash steps in S_HASH, then for each candidate probed S_START,
//   S_MOD (remainder unit), S_PROBE (RAM read) and S_CHECK.
// Read: S_READ presents the slot address, then posts the result. One item at
//   a time; ready returns the cycle after the result posts.
// Reset clears control, then sweeps all TABLE_SLOTS slots (1024 by default)
//   of the slot RAM to zero with input ready held low.
`default_nettype none

module multi_hash_flow_table #(
    parameter int TABLE_SLOTS = mhft_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire mhft_pkg::t_in  i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output mhft_pkg::t_out    o_out_data
);

    import mhft_pkg::*;

    localparam int SW = $clog2(TABLE_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,   // post-reset RAM sweep
        S_IDLE,
        S_HASH,    // hash steps through the shared unit
        S_START,   // kick remainder unit for current candidate
        S_MOD,     // wait for remainder
        S_PROBE,   // RAM read of candidate in flight
        S_CHECK,   // candidate data available
        S_READ     // slot read in flight
    } t_state;

    t_state             r_state;
    t_in                r_in;
    logic [KEY_W-1:0]   r_k;
    logic [STEP_W-1:0]  r_step;
    logic [HASH_W-1:0]  r_h0;
    logic [HASH_W-1:0]  r_h1;
    logic [1:0]         r_probe;
    logic [SW-1:0]      r_cand;
    logic [SW-1:0]      r_clr;
    logic               r_out_valid;
    t_out               r_out;
    logic               r_rd_wait;   // set once the slot read address has been presented

    logic [KEY_W-1:0]   alu_out;
    logic [HASH_W-1:0]  h2;
    logic [HASH_W-1:0]  mod_value;
    logic               mod_start;
    logic               mod_done;
    logic [SW-1:0]      mod_rem;
    logic               out_free;
    logic               out_post;
    logic               ram_we;
    logic [SW-1:0]      ram_waddr;
    logic [ID_W-1:0]    ram_wdata;
    logic [SW-1:0]      ram_raddr;
    logic [ID_W-1:0]    ram_rdata;
    logic [SW-1:0]      rd_addr;
    logic               rd_in_range;
    logic               cand_empty;

    // ---------------------------------------------------------------
    // Shared hash step unit, driven by the step counter
    // ---------------------------------------------------------------
    mhft_hash_alu u_alu (
        .i_k    (r_k),
        .i_step (hash_step(r_step)),
        .o_k    (alu_out)
    );

    assign h2 = r_h0 ^ (r_h1 << 1);

    always_comb begin
        case (r_probe)
            2'd0:    mod_value = r_h0;
            2'd1:    mod_value = r_h1;
            default: mod_value = h2;
        endcase
    end

    assign mod_start = (r_state == S_START);

    mhft_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (mod_value),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // ---------------------------------------------------------------
    // Slot store
    // ---------------------------------------------------------------
    assign out_free    = !r_out_valid || i_out_ready;
    assign cand_empty  = (ram_rdata == '0);
    assign rd_addr     = SW'(r_in.slot_index);
    assign rd_in_range = 32'(r_in.slot_index) < 32'(TABLE_SLOTS);

    // A result is loaded into the output register this cycle
    assign out_post = out_free &&
                      (((r_state == S_CHECK) && (cand_empty || (r_probe == 2'd2))) ||
                       ((r_state == S_READ) && r_rd_wait));

    // Write on the clear sweep, or when the checked candidate is free
    // and the result can be posted in the same cycle.
    assign ram_we    = (r_state == S_CLEAR) ||
                       ((r_state == S_CHECK) && cand_empty && out_free);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_cand;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_in.flow_id;
    // Address held steady while a check waits on the output register
    assign ram_raddr = (r_in.command == CMD_READ) ? rd_addr : r_cand;

    mhft_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_step      <= '0;
            r_probe     <= '0;
            r_out_valid <= 1'b0;
            r_rd_wait   <= 1'b0;
            r_in        <= '0;
        end else begin
            if (out_post) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SW'(TABLE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in      <= i_in_data;
                        r_k       <= KEY_W'(i_in_data.flow_id);
                        r_step    <= '0;
                        r_probe   <= '0;
                        r_rd_wait <= 1'b0;
                        r_state   <= (i_in_data.command == CMD_READ) ? S_READ : S_HASH;
                    end
                end

                S_HASH: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(MIX_LAST)) begin
                        // mix hash done; Wang hash restarts from the id
                        r_h0 <= alu_out[HASH_W-1:0];
                        r_k  <= KEY_W'(r_in.flow_id);
                    end else begin
                        r_k <= alu_out;
                    end
                    if (r_step == STEP_W'(HASH_STEPS - 1)) begin
                        r_h1    <= alu_out[HASH_W-1:0];
                        r_state <= S_START;
                    end
                end

                S_START: begin
                    r_state <= S_MOD;
                end

                S_MOD: begin
                    if (mod_done) begin
                        r_cand  <= mod_rem;
                        r_state <= S_PROBE;
                    end
                end

                S_PROBE: begin
                    r_state <= S_CHECK;
                end

                S_CHECK: begin
                    if (cand_empty || (r_probe == 2'd2)) begin
                        if (out_free) begin
                            r_out.stored_id       <= '0;
                            r_out.first_hash      <= r_h0;
                            r_out.second_hash     <= r_h1;
                            r_out.third_hash      <= h2;
                            if (cand_empty) begin
                                r_out.status <= ST_SLOT0 + STAT_W'(r_probe);
                                r_out.slot   <= IDX_W'(r_cand);
                            end else begin
                                r_out.status <= ST_COLLIDE;
                                r_out.slot   <= '0;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_probe <= r_probe + 1'b1;
                        r_state <= S_START;
                    end
                end

                S_READ: begin
                    // address presented while r_rd_wait is low, read data valid once it is set
                    r_rd_wait <= 1'b1;
                    if (r_rd_wait && out_free) begin
                        r_out.status      <= ST_READ;
                        r_out.slot        <= r_in.slot_index;
                        r_out.stored_id   <= rd_in_range ? ram_rdata : '0;
                        r_out.first_hash  <= '0;
                        r_out.second_hash <= '0;
                        r_out.third_hash  <= '0;
                        r_state           <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Outside the sweep, a slot is only written after it read back empty
    a_write_empty_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state != S_CLEAR)) |-> (ram_rdata == '0))
        else $error("slot written while occupied");

    // Remainder unit output always names a real slot
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (32'(mod_rem) < 32'(TABLE_SLOTS)))
        else $error("remainder not below table size");

    // Insert results carry a consistent third hash
    a_third_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_READ)) |->
        (o_out_data.third_hash ==
         (o_out_data.first_hash ^ (o_out_data.second_hash << 1))))
        else $error("third hash mismatch");

    // A posted result comes only from the check or read states
    a_post_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_CHECK || $past(r_state) == S_READ))
        else $error("result posted from wrong state");

endmodule

`default_nettype wire

/* design/mhft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module mhft_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/mhft_hash_alu.sv */
// One step of the integer hash mixes: shift, add, xor on a 64-bit word.
// Depends on mhft_pkg for the step encoding.
`default_nettype none

module mhft_hash_alu (
    input  wire logic [63:0]                i_k,
    input  wire mhft_pkg::t_hash_step       i_step,
    output logic      [63:0]                o_k
);

    import mhft_pkg::*;

    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] shl;
    logic [KEY_W-1:0] sar;

    // Narrow mode: sign-extend the low word so the low 32 result bits
    // match 32-bit arithmetic with arithmetic right shifts.
    assign a   = i_step.narrow ? {{(KEY_W-HASH_W){i_k[HASH_W-1]}}, i_k[HASH_W-1:0]} : i_k;
    assign shl = a << i_step.shamt;
    assign sar = KEY_W'($signed(a) >>> i_step.shamt);

    always_comb begin
        unique case (i_step.op)
            OP_NOTK_ADD_SHL: o_k = ~a + shl;
            OP_ADD_NOT_SHL:  o_k = a + ~shl;
            OP_ADD_SHL:      o_k = a + shl;
            OP_XOR_SAR:      o_k = a ^ sar;
            OP_MUL21:        o_k = a + (a << 2) + (a << 4);
            default:         o_k = a;
        endcase
    end

endmodule

`default_nettype wire

/* design/mhft_mod.sv */
// Remainder unit: 32-bit value modulo TABLE_SLOTS by reciprocal multiply,
// back-multiply and one correcting subtract. Depends on mhft_pkg.
`default_nettype none

module mhft_mod #(
    parameter int TABLE_SLOTS = mhft_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [31:0]                    i_value,
    output logic                                o_done,
    output logic      [$clog2(TABLE_SLOTS)-1:0] o_rem
);

    import mhft_pkg::*;

    localparam int SW    = $clog2(TABLE_SLOTS);
    // floor(2^SHIFT / N) fits 32 bits and leaves the quotient at most one low
    localparam int SHIFT = HASH_W - 1 + SW;
    localparam logic [KEY_W-1:0]  RECIP_FULL = (KEY_W'(1) << SHIFT) / KEY_W'(TABLE_SLOTS);
    localparam logic [HASH_W-1:0] RECIP      = RECIP_FULL[HASH_W-1:0];
    localparam logic [HASH_W-1:0] DIVISOR    = HASH_W'(TABLE_SLOTS);

    localparam logic [1:0] PH_MUL  = 2'd0;  // value times reciprocal
    localparam logic [1:0] PH_BACK = 2'd1;  // quotient times table size
    localparam logic [1:0] PH_FIX  = 2'd2;  // subtract, correct once

    logic [HASH_W-1:0] r_val;
    logic [KEY_W-1:0]  r_prod;
    logic [HASH_W-1:0] r_qd;
    logic [SW-1:0]     r_rem;
    logic [1:0]        r_phase;
    logic              r_busy;
    logic              r_done;
    logic [HASH_W-1:0] quot;
    logic [HASH_W-1:0] diff;
    logic [SW-1:0]     n_rem;

    assign quot  = HASH_W'(r_prod >> SHIFT);
    assign diff  = r_val - r_qd;
    assign n_rem = (diff >= DIVISOR) ? SW'(diff - DIVISOR) : SW'(diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_MUL;
        end else if (i_start) begin
            r_val   <= i_value;
            r_phase <= PH_MUL;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else if (r_busy) begin
            r_phase <= r_phase + 1'b1;
            unique case (r_phase)
                PH_MUL:  r_prod <= KEY_W'(r_val) * KEY_W'(RECIP);
                PH_BACK: r_qd   <= quot * DIVISOR;
                default: begin
                    r_rem  <= n_rem;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            endcase
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* dv/tb_multi_hash_flow_table.sv */
// Self-checking testbench for the multi-hash flow table: directed and random
// inserts and slot reads, with a built-in table predictor. Depends on mhft_pkg
// and multi_hash_flow_table from the design folder.
`default_nettype none

module tb_multi_hash_flow_table;
    import mhft_pkg::*;

    localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;

    // Per-item idle draw on each side ranges over 0..MAX_IDLE
    localparam int MAX_IDLE = 19;
    // Number of random items after the directed ones
    localparam int RANDOM_ITEMS = 1630;
    // One long receiver hold-off, started after this many results
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 400;
    // Drain wait: covers the longest insert, plus margin
    localparam int DRAIN_CYCLES = 100;
    // Cycles without any transfer before the run is declared hung. Covers the
    // RAM clearing sweep after reset, the long hold-off, and a worst-case insert
    // plus both idle draws, several times over.
    localparam int WATCHDOG_LIMIT = 4 * (TABLE_SLOTS + HOLD_CYCLES + 34 + 2 * MAX_IDLE);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic o_in_ready;
    t_in  in_data = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    t_out o_out_data;

    always #5 clk = ~clk;

    multi_hash_flow_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    // ------------------------------------------------------------------
    // Predictor: shadow copy of the slot table and the three hashes
    // ------------------------------------------------------------------
    logic [ID_W-1:0] shadow_table [TABLE_SLOTS];

    t_in  pending_items[$];      // stimulus not yet offered to the block
    t_out expected_results[$];   // predicted results, oldest first
    logic [ID_W-1:0] id_history[$];

    int fail_count = 0;
    int results_seen = 0;
    int stall_cycles = 0;

    // Arithmetic right shifts; kept in their own assignment so the operand
    // stays signed.
    function automatic logic [63:0] sar64(input logic [63:0] v, input int n);
        logic signed [63:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic logic [31:0] sar32(input logic [31:0] v, input int n);
        logic signed [31:0] s;
        s = v;
        return s >>> n;
    endfunction

    // [0] 64-bit mix truncated, [1] Wang 32-bit, [2] mix ^ (wang << 1)
    function automatic logic [2:0][HASH_W-1:0] flow_hashes(input logic [ID_W-1:0] id);
        logic [63:0] k;
        logic [31:0] w;
        logic [2:0][HASH_W-1:0] h;
        k = {{(64-ID_W){1'b0}}, id};
        k = ~k + (k << 18);
        k = k ^ sar64(k, 31);
        k = k * 64'd21;
        k = k ^ sar64(k, 11);
        k = k + (k << 6);
        k = k ^ sar64(k, 22);
        w = {{(32-ID_W){1'b0}}, id};
        w = w + ~(w << 15);
        w = w ^ sar32(w, 10);
        w = w + (w << 3);
        w = w ^ sar32(w, 6);
        w = w + ~(w << 11);
        w = w ^ sar32(w, 16);
        h[0] = k[31:0];
        h[1] = w;
        h[2] = h[0] ^ (h[1] << 1);
        return h;
    endfunction

    // Updates the shadow table on insert; no duplicate check, zero id
    // "stored" still leaves the slot empty.
    function automatic t_out predict_result(input t_in item);
        t_out r;
        logic [2:0][HASH_W-1:0] h;
        int c;
        r = '0;
        if (item.command == CMD_READ) begin
            r.status = ST_READ;
            r.slot = item.slot_index;
            r.stored_id = (int'(item.slot_index) < TABLE_SLOTS) ?
                          shadow_table[item.slot_index] : '0;
            return r;
        end
        h = flow_hashes(item.flow_id);
        r.first_hash = h[0];
        r.second_hash = h[1];
        r.third_hash = h[2];
        r.status = ST_COLLIDE;
        for (int k = 0; k < 3; k++) begin
            c = int'(h[k] % HASH_W'(TABLE_SLOTS));
            if (shadow_table[c] == '0) begin
                shadow_table[c] = item.flow_id;
                r.status = ST_SLOT0 + STAT_W'(k);
                r.slot = IDX_W'(c);
                break;
            end
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] candidate_slot(input logic [ID_W-1:0] id,
                                                        input int k);
        logic [2:0][HASH_W-1:0] h;
        h = flow_hashes(id);
        return IDX_W'(h[k] % HASH_W'(TABLE_SLOTS));
    endfunction

    function automatic int unsigned idle_draw(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders; the unused field of each command is randomized
    // ------------------------------------------------------------------
    task automatic queue_insert(input logic [ID_W-1:0] id);
        t_in item;
        item.command = CMD_INSERT;
        item.flow_id = id;
        item.slot_index = IDX_W'($urandom);
        pending_items = {pending_items, item};
        id_history = {id_history, id};
    endtask

    task automatic queue_read(input logic [IDX_W-1:0] idx);
        t_in item;
        item.command = CMD_READ;
        item.flow_id = ID_W'($urandom);
        item.slot_index = idx;
        pending_items = {pending_items, item};
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items, random idle between transfers
    // ------------------------------------------------------------------
    int unsigned send_wait = 0;
    bit send_burst = 1'b0;

    always @(posedge clk) begin : send_proc
        int unsigned w;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait <= 0;
        end else if (in_valid && o_in_ready) begin
            // transfer in: predict now, payload is still the accepted one
            expected_results = {expected_results, predict_result(in_data)};
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            w = idle_draw(send_burst);
            if (w == 0 && pending_items.size() != 0) begin
                in_data <= pending_items.pop_front();   // back-to-back, valid stays high
            end else begin
                in_valid <= 1'b0;
                send_wait <= w;
            end
        end else if (!in_valid) begin
            if (send_wait != 0) begin
                send_wait <= send_wait - 1;
            end else if (pending_items.size() != 0) begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random ready stalls, one long hold-off, field compare
    // ------------------------------------------------------------------
    int unsigned ready_wait = 0;
    bit recv_burst = 1'b0;

    always @(posedge clk) begin : recv_proc
        t_out want;
        logic bad;
        int unsigned w;
        if (!rst_n) begin
            out_ready <= 1'b0;
            ready_wait <= 0;
        end else if (o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result with nothing expected: %p", $time, o_out_data);
            end else begin
                want = expected_results.pop_front();
                bad = (o_out_data.status      !== want.status)
                   || (o_out_data.slot        !== want.slot)
                   || (o_out_data.stored_id   !== want.stored_id)
                   || (o_out_data.first_hash  !== want.first_hash)
                   || (o_out_data.second_hash !== want.second_hash)
                   || (o_out_data.third_hash  !== want.third_hash);
                if (bad) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: mismatch status %0d/%0d slot %0d/%0d id %h/%h",
                                 $time, want.status, o_out_data.status, want.slot,
                                 o_out_data.slot, want.stored_id, o_out_data.stored_id);
                        $display("    hashes exp %h %h %h act %h %h %h",
                                 want.first_hash, want.second_hash, want.third_hash,
                                 o_out_data.first_hash, o_out_data.second_hash,
                                 o_out_data.third_hash);
                    end
                end
            end
            results_seen++;
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            // the long hold-off lets the sender back up against in_ready
            w = (results_seen == HOLD_AT) ? HOLD_CYCLES : idle_draw(recv_burst);
            if (w != 0) begin
                out_ready <= 1'b0;
                ready_wait <= w - 1;
            end
        end else if (!out_ready) begin
            if (ready_wait != 0)
                ready_wait <= ready_wait - 1;
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [ID_W-1:0] id;
        int pick;
        for (int i = 0; i < TABLE_SLOTS; i++) shadow_table[i] = '0;

        // Directed: id extremes, zero id (stays empty, so inserts twice at
        // the same slot), duplicates filling all three candidates and then
        // colliding, reads at both slot-index extremes.
        queue_insert(ID_W'(1));
        queue_insert({ID_W{1'b1}});
        queue_insert('0);
        queue_insert('0);
        queue_read(candidate_slot(ID_W'(1), 0));
        queue_read(candidate_slot({ID_W{1'b1}}, 0));
        queue_read(candidate_slot('0, 0));
        queue_read('0);
        queue_read({IDX_W{1'b1}});
        repeat (4) queue_insert(ID_W'(31'h2AAAAAAA));
        for (int k = 0; k < 3; k++) queue_read(candidate_slot(ID_W'(31'h2AAAAAAA), k));
        queue_insert(ID_W'(31'h55555555));
        queue_insert(ID_W'(31'h40000000));
        queue_read(candidate_slot(ID_W'(31'h40000000), 0));
        queue_read(candidate_slot(ID_W'(31'h55555555), 0));

        // Random: fresh ids of several shapes, re-inserts of earlier ids,
        // reads aimed at candidates of earlier ids, and reads anywhere.
        // The table fills as the run goes on, so collisions grow late.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                case ($urandom_range(0, 5))
                    0: id = ID_W'($urandom_range(0, 255));
                    1: id = ID_W'(1) << $urandom_range(0, ID_W - 1);
                    2: id = ~(ID_W'(1) << $urandom_range(0, ID_W - 1));
                    default: id = ID_W'($urandom);
                endcase
                queue_insert(id);
            end else if (pick < 55) begin
                queue_insert(id_history[$urandom_range(0, id_history.size() - 1)]);
            end else if (pick < 80) begin
                id = id_history[$urandom_range(0, id_history.size() - 1)];
                queue_read(candidate_slot(id, $urandom_range(0, 2)));
            end else begin
                queue_read(IDX_W'($urandom));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge, away from the clocked processes
        do @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
